// ----- src/polyphonic_sine_voice_mixer_macros.svh -----
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_mixer_macros.svh
// Assertion macros shared by the voice mixer RTL.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_SINE_VOICE_MIXER_MACROS_SVH
`define POLYPHONIC_SINE_VOICE_MIXER_MACROS_SVH

// clocked property with asynchronous active-low reset disable
`define PSVM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication form: when ante holds, cons holds in the same cycle
`define PSVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle form: when ante holds, cons holds in the next cycle
`define PSVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/psvm_pkg.sv -----
// ----------------------------------------------------------------------------
// psvm_pkg
// Constants, tables, codes and control structs of the sine voice mixer.
// ----------------------------------------------------------------------------
package psvm_pkg;

  // sizes
  localparam int VOICE_COUNT_DFLT = 32;
  localparam int WHITE_KEY_COUNT  = 50;
  localparam int BLACK_KEY_COUNT  = 35;
  localparam int NOTE_COUNT       = 85;
  localparam int SAMPLE_RATE_HZ   = 44100;
  localparam int SINE_TABLE_DEPTH = 1024;

  // sine table geometry (quarter wave plus the end point)
  localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_Q  = SINE_TABLE_DEPTH / 4;
  localparam int SINE_QB = $clog2(SINE_Q);
  localparam int SINE_SH = 30 - SINE_QB;

  // datapath widths
  localparam int QUO_W  = 18;
  localparam int DEN_W  = 49;
  localparam int NUM_W  = 50;
  localparam int DSH_W  = DEN_W + QUO_W - 1;
  localparam int DCNT_W = $clog2(QUO_W);
  localparam int MIX_W  = 20;
  localparam int BUSY_W = 6;
  localparam int MIX_MAX = 524287;
  localparam int MIX_MIN = -524288;

  // operation codes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [1:0] OP_NOTE_OFF = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MIX_GAIN     = 2'd0;
  localparam logic [1:0] CFG_ATTACK_STEP  = 2'd1;
  localparam logic [1:0] CFG_RELEASE_STEP = 2'd2;
  localparam logic [1:0] CFG_DECAY_RATE   = 2'd3;

  localparam logic [15:0] MIX_GAIN_RST     = 16'd16384;
  localparam logic [14:0] ATTACK_STEP_RST  = 15'd328;
  localparam logic [14:0] RELEASE_STEP_RST = 15'd360;
  localparam logic [23:0] DECAY_RATE_RST   = 24'd343597;

  localparam longint Q30_ONE = 64'sd1073741824;

  typedef logic [31:0] step_tab_t [NOTE_COUNT];
  typedef logic [6:0]  wmap_t [WHITE_KEY_COUNT];
  typedef logic [6:0]  bmap_t [BLACK_KEY_COUNT];
  typedef logic [14:0] qsin_t [SINE_Q + 1];

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic clr;
    logic scan;
    logic vsel;
    logic mul1;
    logic mul2;
    logic div_init;
    logic div_step;
    logic acc;
    logic out_load;
  } psvm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       key_ok;
    logic       cur_active;
    logic       cur_freed;
    logic       scan_done;
    logic       idx_last;
    logic       div_last;
    logic       out_busy;
  } psvm_status_t;

  function automatic logic key_is_sharp(int pos);
    return pos inside {1, 3, 6, 8, 10};
  endfunction

  function automatic longint unsigned semitone_q16(int k);
    longint unsigned r;
    case (k)
      0:  r = 65536;
      1:  r = 69433;
      2:  r = 73562;
      3:  r = 77936;
      4:  r = 82570;
      5:  r = 87480;
      6:  r = 92682;
      7:  r = 98193;
      8:  r = 104032;
      9:  r = 110218;
      10: r = 116772;
      default: r = 123715;
    endcase
    return r;
  endfunction

  // phase step per note, MIDI 24 and up
  function automatic step_tab_t build_steps();
    step_tab_t t;
    longint unsigned a16, prod;
    int m, k, oct, sh;
    a16 = (64'd440 << 48) / SAMPLE_RATE_HZ;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      m    = i + 75;
      k    = m % 12;
      oct  = m / 12 - 10;
      sh   = 32 - oct;
      prod = a16 * semitone_q16(k);
      t[i] = 32'((prod + (64'd1 << (sh - 1))) >> sh);
    end
    return t;
  endfunction

  function automatic wmap_t build_white();
    wmap_t t;
    int fill;
    fill = 0;
    for (int i = 0; i < WHITE_KEY_COUNT; i++) t[i] = '0;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      if (!key_is_sharp(i % 12) && fill < WHITE_KEY_COUNT) begin
        t[fill] = 7'(i);
        fill++;
      end
    end
    return t;
  endfunction

  function automatic bmap_t build_black();
    bmap_t t;
    int fill;
    fill = 0;
    for (int i = 0; i < BLACK_KEY_COUNT; i++) t[i] = '0;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      if (key_is_sharp(i % 12) && fill < BLACK_KEY_COUNT) begin
        t[fill] = 7'(i);
        fill++;
      end
    end
    return t;
  endfunction

  function automatic int count_keys(logic blk, int limit);
    int fill;
    fill = 0;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      if ((key_is_sharp(i % 12) == blk) && fill < limit) fill++;
    end
    return fill;
  endfunction

  // sin(pi/2 * z), z and result in Q30
  function automatic longint quarter_sine(longint z);
    longint z2, p;
    z2 = z * z / Q30_ONE;
    p  = 172270;
    p  = -5026996 + p * z2 / Q30_ONE;
    p  = 85569307 + p * z2 / Q30_ONE;
    p  = -693598668 + p * z2 / Q30_ONE;
    p  = 1686629713 + p * z2 / Q30_ONE;
    return p * z / Q30_ONE;
  endfunction

  function automatic qsin_t build_sine();
    qsin_t t;
    longint s;
    for (int k = 0; k <= SINE_Q; k++) begin
      s = quarter_sine(longint'(k) << SINE_SH);
      if (s < 0) s = 0;
      if (s > Q30_ONE) s = Q30_ONE;
      s = (s + 16384) / 32768;
      if (s > 32767) s = 32767;
      t[k] = 15'(s);
    end
    return t;
  endfunction

  localparam step_tab_t NOTE_STEP  = build_steps();
  localparam wmap_t     WHITE_MAP  = build_white();
  localparam bmap_t     BLACK_MAP  = build_black();
  localparam int        WHITE_FILL = count_keys(1'b0, WHITE_KEY_COUNT);
  localparam int        BLACK_FILL = count_keys(1'b1, BLACK_KEY_COUNT);
  localparam qsin_t     SINE_QTAB  = build_sine();

endpackage

// ----- src/psvm_ctrl.sv -----
// ----------------------------------------------------------------------------
// psvm_ctrl
// Sequencer: decodes a beat, walks the voices, drives the shared
// multiply and divide steps and hands the mixed sample to the output.
// ----------------------------------------------------------------------------
module psvm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  psvm_pkg::psvm_status_t status_i,
  output psvm_pkg::psvm_cmd_t    cmd_o
);
  import psvm_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_VSEL   = 4'd3;
  localparam logic [3:0] S_MUL1   = 4'd4;
  localparam logic [3:0] S_MUL2   = 4'd5;
  localparam logic [3:0] S_DIVI   = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_ACC    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.op == OP_TICK) begin
          cmd_o.clr = 1'b1;
          state_d   = S_VSEL;
        end else if ((status_i.op == OP_NOTE_ON || status_i.op == OP_NOTE_OFF)
                     && status_i.key_ok) begin
          cmd_o.clr = 1'b1;
          state_d   = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) state_d = S_IDLE;
      end
      S_VSEL: begin
        cmd_o.vsel = 1'b1;
        if (status_i.cur_active && !status_i.cur_freed) begin
          state_d = S_MUL1;
        end else if (status_i.idx_last) begin
          state_d = S_OUT;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = status_i.idx_last ? S_OUT : S_VSEL;
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/psvm_datapath.sv -----
// ----------------------------------------------------------------------------
// psvm_datapath
// Voice store, key lookup, envelope update, sine lookup, multipliers,
// restoring divider, mix accumulator, configuration and output register.
// ----------------------------------------------------------------------------
module psvm_datapath #(
  parameter int VOICE_COUNT = psvm_pkg::VOICE_COUNT_DFLT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [23:0]            cfg_data_i,
  input  logic [1:0]             operation_i,
  input  logic [5:0]             key_number_i,
  input  logic                   black_key_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [19:0]     mixed_sample_o,
  output logic [5:0]             voices_busy_o,
  input  psvm_pkg::psvm_cmd_t    cmd_i,
  output psvm_pkg::psvm_status_t status_o
);
  import psvm_pkg::*;

  localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CNT_W = $clog2(VOICE_COUNT + 1);
  localparam int ACC_W = QUO_W + CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(MIX_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(MIX_MIN);

  // configuration
  logic [15:0] mix_gain_q;
  logic [14:0] attack_step_q, release_step_q;
  logic [23:0] decay_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_gain_q     <= MIX_GAIN_RST;
      attack_step_q  <= ATTACK_STEP_RST;
      release_step_q <= RELEASE_STEP_RST;
      decay_rate_q   <= DECAY_RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIX_GAIN:     mix_gain_q     <= cfg_data_i[15:0];
        CFG_ATTACK_STEP:  attack_step_q  <= cfg_data_i[14:0];
        CFG_RELEASE_STEP: release_step_q <= cfg_data_i[14:0];
        CFG_DECAY_RATE:   decay_rate_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // key to note lookup on the accepted beat
  logic       key_ok_c;
  logic [6:0] note_c;
  always_comb begin
    key_ok_c = 1'b0;
    note_c   = '0;
    if (black_key_i) begin
      if (int'(key_number_i) < BLACK_FILL) begin
        key_ok_c = 1'b1;
        note_c   = BLACK_MAP[key_number_i];
      end
    end else begin
      if (int'(key_number_i) < WHITE_FILL) begin
        key_ok_c = 1'b1;
        note_c   = WHITE_MAP[key_number_i];
      end
    end
  end

  logic [1:0] op_q;
  logic       key_ok_q;
  logic [6:0] knote_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= operation_i;
      key_ok_q <= key_ok_c;
      knote_q  <= note_c;
    end
  end

  // voice store
  logic [VOICE_COUNT-1:0] active_q, rel_q;
  logic [6:0]  note_q  [VOICE_COUNT];
  logic [31:0] phase_q [VOICE_COUNT];
  logic [15:0] vol_q   [VOICE_COUNT];
  logic [23:0] age_q   [VOICE_COUNT];
  logic [IDX_W-1:0] idx_q;

  logic        cur_active, cur_rel, cur_freed;
  logic [6:0]  cur_note;
  logic [31:0] cur_phase;
  logic [15:0] cur_vol, vol_new;
  logic [23:0] cur_age, age_new;
  assign cur_active = active_q[idx_q];
  assign cur_rel    = rel_q[idx_q];
  assign cur_note   = note_q[idx_q];
  assign cur_phase  = phase_q[idx_q];
  assign cur_vol    = vol_q[idx_q];
  assign cur_age    = age_q[idx_q];

  // envelope update
  always_comb begin
    cur_freed = cur_rel && (cur_vol <= {1'b0, release_step_q});
    if (cur_rel) begin
      vol_new = cur_vol - {1'b0, release_step_q};
      age_new = cur_age;
    end else begin
      vol_new = cur_vol[15] ? cur_vol : cur_vol + {1'b0, attack_step_q};
      age_new = (&cur_age) ? cur_age : cur_age + 24'd1;
    end
  end

  // sine lookup by quarter-wave symmetry
  logic [SINE_AW-1:0] sidx;
  logic [SINE_QB:0]   qk;
  logic [14:0]        s_mag;
  assign sidx  = cur_phase[31 -: SINE_AW];
  assign qk    = sidx[SINE_AW-2] ? ((SINE_QB+1)'(SINE_Q) - {1'b0, sidx[SINE_AW-3:0]})
                                 : {1'b0, sidx[SINE_AW-3:0]};
  assign s_mag = SINE_QTAB[qk];

  // flags, with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      rel_q    <= '0;
    end else begin
      if (cmd_i.scan) begin
        if (op_q == OP_NOTE_ON && !cur_active) begin
          active_q[idx_q] <= 1'b1;
          rel_q[idx_q]    <= 1'b0;
        end else if (op_q == OP_NOTE_OFF && cur_active && cur_note == knote_q) begin
          rel_q[idx_q] <= 1'b1;
        end
      end
      if (cmd_i.vsel && cur_active && cur_freed) active_q[idx_q] <= 1'b0;
    end
  end

  // voice payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && op_q == OP_NOTE_ON && !cur_active) begin
      note_q[idx_q]  <= knote_q;
      phase_q[idx_q] <= '0;
      vol_q[idx_q]   <= '0;
      age_q[idx_q]   <= '0;
    end
    if (cmd_i.vsel && cur_active) begin
      vol_q[idx_q]   <= vol_new;
      age_q[idx_q]   <= age_new;
      phase_q[idx_q] <= cur_phase + NOTE_STEP[cur_note];
    end
  end

  // term pipeline and divider
  logic [14:0]      s_abs_q;
  logic             s_neg_q, trel_q;
  logic [15:0]      tvol_q;
  logic [23:0]      tage_q;
  logic [30:0]      p1_q;
  logic [47:0]      dprod_q;
  logic [46:0]      p2_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] rem_q;
  logic [DSH_W-1:0] dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic             div_ge;

  assign div_ge = {{(DSH_W-NUM_W){1'b0}}, rem_q} >= dsh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.vsel) begin
      s_abs_q <= s_mag;
      s_neg_q <= sidx[SINE_AW-1];
      tvol_q  <= vol_new;
      tage_q  <= age_new;
      trel_q  <= cur_rel;
    end
    if (cmd_i.mul1) begin
      p1_q    <= 31'(s_abs_q) * 31'(tvol_q);
      dprod_q <= trel_q ? '0 : 48'(decay_rate_q) * 48'(tage_q);
    end
    if (cmd_i.mul2) begin
      p2_q  <= 47'(p1_q) * 47'(mix_gain_q);
      den_q <= (DEN_W'(1) << 32) + DEN_W'(dprod_q);
    end
    if (cmd_i.div_init) begin
      rem_q  <= {p2_q, 2'b00} + NUM_W'(den_q >> 1);
      dsh_q  <= DSH_W'(den_q) << (QUO_W - 1);
      quo_q  <= '0;
      dcnt_q <= DCNT_W'(QUO_W - 1);
    end else if (cmd_i.div_step) begin
      if (div_ge) rem_q <= rem_q - dsh_q[NUM_W-1:0];
      quo_q  <= {quo_q[QUO_W-2:0], div_ge};
      dsh_q  <= dsh_q >> 1;
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
  end

  // voice index, mix accumulator and busy count
  logic signed [ACC_W-1:0] acc_q, term_c;
  logic [CNT_W-1:0]        busy_q;
  assign term_c = s_neg_q ? -$signed({{(ACC_W-QUO_W){1'b0}}, quo_q})
                          :  $signed({{(ACC_W-QUO_W){1'b0}}, quo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      acc_q  <= '0;
      busy_q <= '0;
    end else begin
      if (cmd_i.clr) begin
        idx_q  <= '0;
        acc_q  <= '0;
        busy_q <= '0;
      end else begin
        if (cmd_i.scan || cmd_i.acc || (cmd_i.vsel && !(cur_active && !cur_freed)))
          idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
        if (cmd_i.acc) acc_q <= acc_q + term_c;
        if (cmd_i.vsel && cur_active && !cur_freed) busy_q <= busy_q + CNT_W'(1);
      end
    end
  end

  // output register
  logic                   out_valid_q;
  logic signed [MIX_W-1:0] mix_q;
  logic [BUSY_W-1:0]      busy_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (acc_q > ACC_MAX)      mix_q <= MIX_W'(MIX_MAX);
      else if (acc_q < ACC_MIN) mix_q <= MIX_W'(MIX_MIN);
      else                      mix_q <= acc_q[MIX_W-1:0];
      busy_out_q <= BUSY_W'(busy_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = mix_q;
  assign voices_busy_o  = busy_out_q;

  // status
  always_comb begin
    status_o            = '0;
    status_o.op         = op_q;
    status_o.key_ok     = key_ok_q;
    status_o.cur_active = cur_active;
    status_o.cur_freed  = cur_freed;
    status_o.idx_last   = (idx_q == LAST_IDX);
    status_o.scan_done  = (op_q == OP_NOTE_ON && !cur_active) || (idx_q == LAST_IDX);
    status_o.div_last   = (dcnt_q == '0);
    status_o.out_busy   = out_valid_q && !out_ready_i;
  end

endmodule

// ----- src/polyphonic_sine_voice_mixer.sv -----
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_mixer
// Polyphonic sine voice mixer: note-on/off control and one mixed,
// saturated sample per tick beat.
//
//   channel | signals                                          | dir
//   --------+--------------------------------------------------+----
//   in      | in_valid_i in_ready_o operation_i key_number_i    | in
//           | black_key_i                                      |
//   out     | out_valid_o out_ready_i mixed_sample_o           | out
//           | voices_busy_o                                    |
//   cfg     | cfg_we_i cfg_index_i cfg_data_i                  | in
//
// A note-on/off beat scans the voices in order. A tick beat visits every
// voice and runs the shared multiply/divide unit (18-step restoring
// divider) for each active voice that is not yet freed.
// Reset clears all voices and loads the default register values.
// A stalled output holds only the final load; input is taken when idle.
// ----------------------------------------------------------------------------
`include "polyphonic_sine_voice_mixer_macros.svh"

module polyphonic_sine_voice_mixer #(
  parameter int VOICE_COUNT = psvm_pkg::VOICE_COUNT_DFLT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [5:0]         key_number_i,
  input  logic               black_key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [19:0] mixed_sample_o,
  output logic [5:0]         voices_busy_o
);
  import psvm_pkg::*;

  psvm_cmd_t    cmd;
  psvm_status_t status;
  logic         load_ok, div_end, dp_busy;

  // sequencer
  psvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  psvm_datapath #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .key_number_i   (key_number_i),
    .black_key_i    (black_key_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mixed_sample_o (mixed_sample_o),
    .voices_busy_o  (voices_busy_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

  // checks
  assign load_ok = !out_valid_o || out_ready_i;
  assign div_end = cmd.div_step && status.div_last;
  assign dp_busy = cmd.div_step || cmd.mul1 || cmd.vsel || cmd.scan;

  `PSVM_ASSERT_IMP(a_load_free, clk_i, rst_ni, cmd.out_load, load_ok, "output overwritten")
  `PSVM_ASSERT_NXT(a_div_to_acc, clk_i, rst_ni, div_end, cmd.acc, "divide without accumulate")
  `PSVM_ASSERT(a_idle_quiet, clk_i, rst_ni, !in_ready_o || !dp_busy, "datapath busy while ready")

endmodule
